FILE: rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants of the Miller-Rabin round core: stream widths,
// result bit positions and the codes that select a modular multiply's target.
// ----------------------------------------------------------------------------
package mrr_pkg;

    // input fields are fixed at 32 bits each on the stream
    localparam int IN_FIELD_W = 32;
    localparam int S_TDATA_W  = 2 * IN_FIELD_W;
    localparam int M_TDATA_W  = 8;

    // result bit positions in m_tdata
    localparam int RES_PRIME   = 0;
    localparam int RES_INVALID = 1;
    localparam int RES_CORNER  = 2;

    // where a finished modular product goes
    typedef logic [1:0] mul_op_t;
    localparam mul_op_t OP_MUL_R  = 2'd0;  // r = r * base
    localparam mul_op_t OP_SQR_B  = 2'd1;  // base = base * base
    localparam mul_op_t OP_SQR_X  = 2'd2;  // x = x * x

endpackage

FILE: rtl/miller_rabin_round_core.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_core
// One round of the Miller-Rabin probable-prime test per input transfer.
//
// Each transfer carries a candidate and a witness base and yields one result
// transfer. Candidates of 4 or less are decided at once (2 and 3 prime), and
// a witness outside 2..candidate-2 is flagged invalid without any arithmetic;
// both go straight from the accepting state to the result state. Otherwise
// the core strips factors of two from candidate-1, raises the witness to the
// odd part by right-to-left square-and-multiply, then squares up to s-1
// times. Every modular product goes through one shared shift-add modular
// multiplier that consumes one multiplier bit per cycle; a round takes
// roughly (bits(d) + popcount(d) + s - 2) products. One item is worked
// on at a time; the next one is taken while a finished result waits in the
// output register.
// ----------------------------------------------------------------------------
module miller_rabin_round_core #(
    parameter int WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [31:0] candidate, [63:32] witness
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mrr_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: [0] probably_prime, [1] witness_invalid, [2] by_corner_case,
    // [7:3] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mrr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mrr_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STRIP = 3'd1;
    localparam logic [2:0] ST_EXP   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_FIRST = 3'd4;
    localparam logic [2:0] ST_SQ    = 3'd5;
    localparam logic [2:0] ST_SQCHK = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
    localparam logic [WIDTH-1:0] TWO = WIDTH'(2);
    localparam logic [WIDTH-1:0] FOUR = WIDTH'(4);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // (a + b) mod m for a, b < m; the extra bit catches the wrap
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] a,
        input logic [WIDTH-1:0] b,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] sum;
        logic [WIDTH:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = sum - {1'b0, m};
        add_mod = (sum >= {1'b0, m}) ? red[WIDTH-1:0] : sum[WIDTH-1:0];
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [WIDTH-1:0] r_reg, r_next;       // running power, later x
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] ma_reg, ma_next;
    logic [WIDTH-1:0] mb_reg, mb_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mul_op_t          op_reg, op_next;
    logic             prime_reg, prime_next;
    logic             invalid_reg, invalid_next;
    logic             corner_reg, corner_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [WIDTH-1:0] cand_in;
    logic [WIDTH-1:0] wit_in;
    logic [WIDTH-1:0] n_minus1;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] step;

    assign cand_in  = WIDTH'(s_tdata[IN_FIELD_W-1:0]);
    assign wit_in   = WIDTH'(s_tdata[S_TDATA_W-1:IN_FIELD_W]);
    assign n_minus1 = n_reg - ONE;

    // one multiplier bit per cycle, msb first
    assign dbl  = add_mod(acc_reg, acc_reg, n_reg);
    assign step = mb_reg[WIDTH-1] ? add_mod(dbl, ma_reg, n_reg) : dbl;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        s_next        = s_reg;
        r_next        = r_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        prime_next    = prime_reg;
        invalid_next  = invalid_reg;
        corner_next   = corner_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next       = cand_in;
                    d_next       = cand_in - ONE;
                    s_next       = '0;
                    r_next       = ONE;
                    base_next    = wit_in;
                    prime_next   = 1'b0;
                    invalid_next = 1'b0;
                    corner_next  = 1'b0;
                    if (cand_in <= FOUR) begin
                        corner_next = 1'b1;
                        prime_next  = (cand_in == TWO) || (cand_in == WIDTH'(3));
                        state_next  = ST_DONE;
                    end else if ((wit_in < TWO) || (wit_in > cand_in - TWO)) begin
                        invalid_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        state_next = ST_STRIP;
                    end
                end
            end
            ST_STRIP: begin
                if (!d_reg[0]) begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + CNT_ONE;
                end else begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                acc_next = '0;
                cnt_next = '0;
                if (d_reg == '0) begin
                    state_next = ST_FIRST;
                end else if (d_reg[0]) begin
                    op_next    = OP_MUL_R;
                    ma_next    = r_reg;
                    mb_next    = base_reg;
                    state_next = ST_MUL;
                end else if (d_reg[WIDTH-1:1] == '0) begin
                    // last bit handled, the final squaring is not needed
                    d_next = '0;
                end else begin
                    op_next    = OP_SQR_B;
                    ma_next    = base_reg;
                    mb_next    = base_reg;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next = step;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_LAST) begin
                    case (op_reg)
                        OP_MUL_R: begin
                            r_next     = step;
                            d_next     = {d_reg[WIDTH-1:1], 1'b0};
                            state_next = ST_EXP;
                        end
                        OP_SQR_B: begin
                            base_next  = step;
                            d_next     = d_reg >> 1;
                            state_next = ST_EXP;
                        end
                        OP_SQR_X: begin
                            r_next     = step;
                            state_next = ST_SQCHK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIRST: begin
                if ((r_reg == ONE) || (r_reg == n_minus1)) begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                acc_next = '0;
                cnt_next = '0;
                if (s_reg > CNT_ONE) begin
                    s_next     = s_reg - CNT_ONE;
                    op_next    = OP_SQR_X;
                    ma_next    = r_reg;
                    mb_next    = r_reg;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SQCHK: begin
                if (r_reg == ONE) begin
                    state_next = ST_DONE;
                end else if (r_reg == n_minus1) begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next              = 1'b1;
                    m_tdata_next               = '0;
                    m_tdata_next[RES_PRIME]    = prime_reg;
                    m_tdata_next[RES_INVALID]  = invalid_reg;
                    m_tdata_next[RES_CORNER]   = corner_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        s_reg       <= s_next;
        r_reg       <= r_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        cnt_reg     <= cnt_next;
        op_reg      <= op_next;
        prime_reg   <= prime_next;
        invalid_reg <= invalid_next;
        corner_reg  <= corner_next;
        m_tdata_reg <= m_tdata_next;
    end

    // partial product always stays reduced below the modulus
    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (acc_reg < n_reg))
        else $error("modular accumulator not reduced");

    // a result is never both a corner case and an invalid witness
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[RES_CORNER] && m_tdata_reg[RES_INVALID]))
        else $error("corner and invalid flags both set");

    // an invalid witness never passes
    a_invalid_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[RES_INVALID]) |-> !m_tdata_reg[RES_PRIME])
        else $error("invalid witness reported prime");

    // an accepted transfer always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("core stayed idle after accepting a transfer");

    // the exponent is odd once stripping is over and before any multiply
    a_odd_exponent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STRIP && d_reg[0]) |=> (state_reg == ST_EXP && d_reg[0]))
        else $error("odd part lost after stripping");

endmodule
